/* rtl/lfdf_pkg.sv */
`default_nettype none

package lfdf_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int MAX_MSG_BYTES_DEF = 512;
  localparam int ENTRY_BYTES_DEF   = 8;

  // Message layout and hash constants
  localparam logic [31:0] HASH_INIT = 32'd1315423911;
  localparam int SKIP_BYTES   = 4;
  localparam int COUNT_BYTES  = 4;
  localparam int HEADER_BYTES = 12;
  localparam int HASH_SHL     = 5;
  localparam int HASH_SHR     = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } lfdf_in_t;

  typedef struct packed {
    logic        is_new;
    logic        corrupt;
    logic        table_full;
    logic [31:0] hash_value;
  } lfdf_out_t;

  // Finished message handed from the accumulator to the table search
  typedef struct packed {
    logic        bad;
    logic [31:0] hash;
  } lfdf_msg_t;

  // One JS hash step; the byte is sign-extended as a C char
  function automatic logic [31:0] js_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] ext;
    ext = {{24{b[7]}}, b};
    return h ^ ((h << HASH_SHL) + ext + (h >> HASH_SHR));
  endfunction

endpackage

`default_nettype wire

/* rtl/lfdf_ram.sv */
`default_nettype none

module lfdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/lfdf_accum.sv */
`default_nettype none

module lfdf_accum #(
  parameter int MAX_MSG_BYTES = lfdf_pkg::MAX_MSG_BYTES_DEF,
  parameter int ENTRY_BYTES   = lfdf_pkg::ENTRY_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                byte_valid_i,
  input  wire lfdf_pkg::lfdf_in_t  byte_i,
  output logic                     msg_valid_o,
  output lfdf_pkg::lfdf_msg_t      msg_o
);

  import lfdf_pkg::*;

  localparam int PW = $clog2(MAX_MSG_BYTES + 1);
  localparam int EW = $clog2(ENTRY_BYTES + 1);
  localparam int XW = PW + EW + 1;

  logic [31:0]   hash_q, hash_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0]   count_q, count_d;

  logic [31:0]   fin_hash_q, fin_hash_d;
  logic [31:0]   fin_count_q, fin_count_d;
  logic [PW-1:0] fin_pos_q, fin_pos_d;
  logic          fin_valid_q, fin_valid_d;

  logic [31:0]   hash_nxt, count_nxt;
  logic [PW:0]   total;
  logic [PW+EW-1:0] prod;
  logic [XW-1:0] expect_len;
  logic          overlong, count_hi;

  always_comb begin
    hash_nxt  = hash_q;
    count_nxt = count_q;
    if (pos_q >= PW'(SKIP_BYTES)) begin
      hash_nxt = js_mix(hash_q, byte_i.data_byte);
    end
    if (pos_q inside {[SKIP_BYTES:SKIP_BYTES+COUNT_BYTES-1]}) begin
      count_nxt = count_q | (32'(byte_i.data_byte) << {pos_q[1:0], 3'b000});
    end
  end

  always_comb begin
    hash_d      = hash_q;
    pos_d       = pos_q;
    count_d     = count_q;
    fin_hash_d  = fin_hash_q;
    fin_count_d = fin_count_q;
    fin_pos_d   = fin_pos_q;
    fin_valid_d = 1'b0;
    if (byte_valid_i) begin
      if (byte_i.is_last) begin
        // capture the message, then restart for the next one
        fin_hash_d  = hash_nxt;
        fin_count_d = count_nxt;
        fin_pos_d   = pos_q;
        fin_valid_d = 1'b1;
        hash_d      = HASH_INIT;
        pos_d       = '0;
        count_d     = '0;
      end else begin
        hash_d  = hash_nxt;
        count_d = count_nxt;
        if (pos_q < PW'(MAX_MSG_BYTES)) begin
          pos_d = pos_q + PW'(1);
        end
      end
    end
  end

  // Length check: a count wider than the position can never match
  always_comb begin
    total      = (PW+1)'(fin_pos_q) + (PW+1)'(1);
    overlong   = (fin_pos_q == PW'(MAX_MSG_BYTES));
    count_hi   = (fin_count_q[31:PW] != '0);
    prod       = (PW+EW)'(fin_count_q[PW-1:0]) * (PW+EW)'(ENTRY_BYTES);
    expect_len = XW'(prod) + XW'(HEADER_BYTES);
  end

  assign msg_valid_o = fin_valid_q;
  assign msg_o.hash  = fin_hash_q;
  assign msg_o.bad   = overlong | count_hi | (expect_len != XW'(total));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= HASH_INIT;
      pos_q       <= '0;
      count_q     <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_hash_q  <= fin_hash_d;
    fin_count_q <= fin_count_d;
    fin_pos_q   <= fin_pos_d;
  end

endmodule

`default_nettype wire

/* rtl/lfdf_search.sv */
`default_nettype none

module lfdf_search #(
  parameter int TABLE_DEPTH = lfdf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 msg_valid_i,
  input  wire lfdf_pkg::lfdf_msg_t  msg_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lfdf_pkg::lfdf_out_t       out_data_o
);

  import lfdf_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [31:0]     hash_q, hash_d;
  lfdf_out_t       res_q, res_d;
  lfdf_out_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata, ram_rdata;
  logic            has_room;

  lfdf_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign has_room  = (cnt_q < CNTW'(TABLE_DEPTH));
  assign ram_waddr = cnt_q[AW-1:0];
  assign ram_wdata = (state_q == S_IDLE) ? msg_i.hash : hash_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    hash_d      = hash_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (msg_valid_i) begin
          hash_d           = msg_i.hash;
          res_d            = '0;
          res_d.hash_value = msg_i.hash;
          idx_d            = '0;
          if (msg_i.bad) begin
            res_d.corrupt = 1'b1;
            state_d       = S_FIN;
          end else if (cnt_q == '0) begin
            // empty table: store at once
            ram_we       = 1'b1;
            cnt_d        = cnt_q + CNTW'(1);
            res_d.is_new = 1'b1;
            state_d      = S_FIN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (ram_rdata == hash_q) begin
          // duplicate: all flags stay clear
          state_d = S_FIN;
        end else if (CNTW'(idx_q) + CNTW'(1) == cnt_q) begin
          if (has_room) begin
            ram_we       = 1'b1;
            cnt_d        = cnt_q + CNTW'(1);
            res_d.is_new = 1'b1;
          end else begin
            res_d.table_full = 1'b1;
          end
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_READ;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    hash_q <= hash_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

/* rtl/lsa_flood_duplicate_filter.sv */
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (data_byte, is_last)
// out       output     out_valid_o / out_stall_i out_data_o (is_new, corrupt,
//                                                 table_full, hash_value)
//
// Bytes are taken back to back; after the last byte of a message the input stalls
// for the length check, a read and a compare per stored entry searched through the
// RAM's single read port, and the result load once the output register is free.
// A corrupt message or an empty table skips the search; a duplicate ends it early.
// Reset empties the table by clearing its fill count; the RAM is not swept.
// A stalled result waits in the output register while the next message flows in.
module lsa_flood_duplicate_filter #(
  parameter int TABLE_DEPTH   = lfdf_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_MSG_BYTES = lfdf_pkg::MAX_MSG_BYTES_DEF,
  parameter int ENTRY_BYTES   = lfdf_pkg::ENTRY_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire lfdf_pkg::lfdf_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lfdf_pkg::lfdf_out_t      out_data_o
);

  import lfdf_pkg::*;

  logic      byte_accept;
  logic      msg_valid;
  lfdf_msg_t msg;
  logic      search_busy;

  // Stall while a finished message is checked or searched
  assign in_stall_o  = msg_valid | search_busy;
  assign byte_accept = in_valid_i & ~in_stall_o;

  lfdf_accum #(
    .MAX_MSG_BYTES(MAX_MSG_BYTES),
    .ENTRY_BYTES  (ENTRY_BYTES)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_accept),
    .byte_i      (in_data_i),
    .msg_valid_o (msg_valid),
    .msg_o       (msg)
  );

  lfdf_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .msg_valid_i(msg_valid),
    .msg_i      (msg),
    .busy_o     (search_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfdf_pkg::*;

  // Sizes follow the defaults of the block under test
  localparam int DEPTH     = TABLE_DEPTH_DEF;
  localparam int MAX_BYTES = MAX_MSG_BYTES_DEF;
  localparam int ENTRY     = ENTRY_BYTES_DEF;

  // Stimulus volume and run limits
  localparam int RANDOM_BYTES   = 1500;
  localparam int OVERLONG_AT    = 300;
  localparam int PHASE_BYTES    = 600;
  localparam int HOLD_CYCLES    = 400;
  // Longest quiet stretch: the long hold-off plus a full table search
  // plus a long random receiver stall, taken many times over
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;

  // Kinds of message the random part builds
  typedef enum logic [2:0] {
    MSG_VALID,
    MSG_DUP,
    MSG_SHORT,
    MSG_BAD_LEN,
    MSG_HUGE_COUNT,
    MSG_NOISE
  } msg_kind_e;

  // One row of the directed table; res is used only where pinned is set
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       pinned;
    lfdf_out_t  res;
  } plan_row_t;

  // A hand-written expectation tied to the input transaction that ends a message
  typedef struct {
    int unsigned seq;
    lfdf_out_t   res;
  } pin_t;

  localparam lfdf_out_t NO_RES    = '0;
  // A lone byte never reaches the hash: corrupt, hash still at its seed
  localparam lfdf_out_t SHORT_RES = '{is_new: 1'b0, corrupt: 1'b1, table_full: 1'b0,
                                      hash_value: HASH_INIT};

  localparam int PLAN_ROWS = 25;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // one-byte message: short, flagged corrupt
    '{8'hFF, 1'b1, 1'b1, SHORT_RES},
    // own message, count zero: seeds the table
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES}, '{8'h7F, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b0, 1'b0, NO_RES}, '{8'h01, 1'b1, 1'b0, NO_RES},
    // same body from another source: duplicate, since the source is skipped
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b0, 1'b0, NO_RES}, '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b0, 1'b0, NO_RES}, '{8'h01, 1'b1, 1'b0, NO_RES}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lfdf_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  lfdf_out_t out_data;

  // Predictor state: the message being hashed and the table of seen hashes
  logic [31:0] msg_hash  = HASH_INIT;
  int unsigned msg_pos   = 0;
  logic [31:0] msg_count = '0;
  logic [31:0] seen_tab [DEPTH];
  int unsigned seen_n    = 0;

  lfdf_out_t   verdict_q [$];
  pin_t        pinned_q [$];
  logic [7:0]  msg_buf [$];
  logic [31:0] dup_tails [$];

  int unsigned bytes_sent   = 0;
  int unsigned items_seen   = 0;
  int unsigned errs         = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 38;
  int unsigned rcv_idle_pct = 83;
  bit          hold_req     = 1'b0;

  lsa_flood_duplicate_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the filter by one byte. On the last byte, check the length,
  // search and update the seen table, then clear the message state.
  task automatic advance_filter(input lfdf_in_t it, output logic has_res,
                                output lfdf_out_t res);
    int unsigned p;
    logic [31:0] ext;
    logic [63:0] want_len;
    logic        bad;
    logic        found;
    p       = msg_pos;
    res     = '0;
    has_res = 1'b0;
    // hash every byte past the source field, sign-extended as a C char
    if (p >= SKIP_BYTES) begin
      ext      = {{24{it.data_byte[7]}}, it.data_byte};
      msg_hash = msg_hash ^ ((msg_hash << HASH_SHL) + ext + (msg_hash >> HASH_SHR));
    end
    // capture the neighbor count little-endian
    if (p >= SKIP_BYTES && p < SKIP_BYTES + COUNT_BYTES)
      msg_count = msg_count | (32'(it.data_byte) << (8 * (p - SKIP_BYTES)));
    // saturate the position so an overlong message stays overlong
    if (msg_pos < MAX_BYTES)
      msg_pos++;
    if (it.is_last) begin
      has_res  = 1'b1;
      // compute the expected length in 64 bits so a huge count cannot wrap
      want_len = 64'(msg_count) * ENTRY + HEADER_BYTES;
      bad      = (p + 1 > MAX_BYTES) || (want_len != 64'(p + 1));
      res.hash_value = msg_hash;
      if (bad) begin
        res.corrupt = 1'b1;
      end else begin
        found = 1'b0;
        for (int unsigned i = 0; i < seen_n; i++)
          if (seen_tab[i] == msg_hash)
            found = 1'b1;
        if (!found) begin
          if (seen_n < DEPTH) begin
            seen_tab[seen_n] = msg_hash;
            seen_n++;
            res.is_new = 1'b1;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      msg_hash  = HASH_INIT;
      msg_pos   = 0;
      msg_count = '0;
    end
  endtask

  // Fill msg_buf with len bytes: random source and body, count field set to cnt
  task automatic build_framed(input logic [31:0] cnt, input int unsigned len);
    msg_buf = {};
    for (int unsigned i = 0; i < len; i++) begin
      if (i >= SKIP_BYTES && i < SKIP_BYTES + COUNT_BYTES)
        msg_buf = {msg_buf, 8'(cnt >> (8 * (i - SKIP_BYTES)))};
      else
        msg_buf = {msg_buf, 8'($urandom)};
    end
  endtask

  // Offer one byte, idling first at random, and hold it until accepted.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, is_last: last};
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Scoreboard: check the output transaction against the oldest expectation,
  // then predict from the input transaction taken at the same edge.
  always @(posedge clk) begin
    lfdf_out_t want;
    lfdf_out_t res;
    logic      has_res;
    pin_t      pin;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: hash_value %h", out_data.hash_value);
          errs++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.is_new !== want.is_new) begin
            $error("is_new: expected %0d, actual %0d", want.is_new, out_data.is_new);
            errs++;
          end
          if (out_data.corrupt !== want.corrupt) begin
            $error("corrupt: expected %0d, actual %0d", want.corrupt, out_data.corrupt);
            errs++;
          end
          if (out_data.table_full !== want.table_full) begin
            $error("table_full: expected %0d, actual %0d", want.table_full,
                   out_data.table_full);
            errs++;
          end
          if (out_data.hash_value !== want.hash_value) begin
            $error("hash_value: expected %h, actual %h", want.hash_value,
                   out_data.hash_value);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_filter(in_data, has_res, res);
        if (has_res) begin
          // a hand-written row overrides the prediction for its transaction
          if (pinned_q.size() != 0 && pinned_q[0].seq == items_seen) begin
            pin = pinned_q.pop_front();
            res = pin.res;
          end
          verdict_q = {verdict_q, res};
        end
        items_seen++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** lsa_flood_duplicate_filter: FAILED **");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Sender: directed table, then random messages in three idling phases
  initial begin
    msg_kind_e   kind;
    int unsigned r;
    int unsigned cnt;
    int unsigned len;
    int unsigned delta;
    logic [31:0] tail;
    bit          overlong_done;
    bit          hold_done;
    pin_t        pin;
    overlong_done = 1'b0;
    hold_done     = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].pinned) begin
        pin.seq = bytes_sent;
        pin.res = PLAN[i].res;
        pinned_q = {pinned_q, pin};
      end
      send_item(PLAN[i].data_byte, PLAN[i].is_last);
    end

    // Random messages, mostly short well-formed ones so the table overflows
    while (bytes_sent < RANDOM_BYTES) begin
      // Swap the idling roles, then drop idling and stall the output hard
      if (bytes_sent < PHASE_BYTES) begin
        src_idle_pct = 38;
        rcv_idle_pct = 83;
      end else if (bytes_sent < 2 * PHASE_BYTES) begin
        src_idle_pct = 83;
        rcv_idle_pct = 38;
      end else begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        if (!hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end

      r = $urandom_range(99);
      if (r < 90)      kind = MSG_VALID;
      else if (r < 92) kind = MSG_DUP;
      else if (r < 95) kind = MSG_SHORT;
      else if (r < 97) kind = MSG_BAD_LEN;
      else if (r < 99) kind = MSG_HUGE_COUNT;
      else             kind = MSG_NOISE;
      if (kind == MSG_DUP && dup_tails.size() == 0)
        kind = MSG_VALID;

      if (!overlong_done && bytes_sent >= OVERLONG_AT) begin
        // length matches the count but runs past the maximum: corrupt
        build_framed(63, 63 * ENTRY + HEADER_BYTES);
        overlong_done = 1'b1;
      end else begin
        case (kind)
          MSG_VALID: begin
            cnt = ($urandom_range(31) == 0) ? $urandom_range(1, 2) : 0;
            build_framed(cnt, cnt * ENTRY + HEADER_BYTES);
            // remember short well-formed bodies for later replay
            if (cnt == 0) begin
              dup_tails = {dup_tails, {msg_buf[11], msg_buf[10], msg_buf[9], msg_buf[8]}};
              if (dup_tails.size() > 32)
                void'(dup_tails.pop_front());
            end
          end
          MSG_DUP: begin
            // replay a body under a fresh source field
            tail = dup_tails[$urandom_range(dup_tails.size() - 1)];
            build_framed(0, HEADER_BYTES);
            for (int k = 0; k < 4; k++)
              msg_buf[8 + k] = tail[8 * k +: 8];
          end
          MSG_SHORT: begin
            build_framed($urandom, $urandom_range(1, HEADER_BYTES - 1));
          end
          MSG_BAD_LEN: begin
            cnt   = $urandom_range(0, 1);
            len   = cnt * ENTRY + HEADER_BYTES;
            delta = $urandom_range(1, ENTRY - 1);
            len   = $urandom_range(1) ? len + delta : len - delta;
            build_framed(cnt, len);
          end
          MSG_HUGE_COUNT: begin
            // counts whose product wraps to a matching length in 32 bits
            cnt = $urandom_range(0, 1);
            len = cnt * ENTRY + HEADER_BYTES;
            case ($urandom_range(2))
              0:       build_framed(32'h2000_0000 + cnt, len);
              1:       build_framed(32'hE000_0000 + cnt, len);
              default: build_framed(32'hFFFF_FFFF, $urandom_range(HEADER_BYTES, 24));
            endcase
          end
          default: begin
            build_framed($urandom, $urandom_range(1, 24));
          end
        endcase
      end

      foreach (msg_buf[j])
        send_item(msg_buf[j], j == msg_buf.size() - 1);
    end
    in_valid <= 1'b0;

    // Drain: wait for every result, then watch for strays
    while (verdict_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errs == 0 && verdict_q.size() == 0) begin
      $display("** lsa_flood_duplicate_filter: PASSED **");
    end else begin
      $display("** lsa_flood_duplicate_filter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/lfdf_pkg.sv
rtl/lfdf_ram.sv
rtl/lfdf_accum.sv
rtl/lfdf_search.sv
rtl/lsa_flood_duplicate_filter.sv
verif/tb_top.sv
